// ===== src/pip_pkg.sv =====
// Shared types and constants for the even-odd point-in-polygon block.
package pip_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_POINT_X = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_POINT_Y = 1'b1;

	localparam int EQ_DEPTH = 2;
	localparam int EQ_PTR_W = $clog2(EQ_DEPTH);
	localparam int EQ_CNT_W = $clog2(EQ_DEPTH + 1);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	// One edge, endpoints ordered by y; crossing when dx*dpy <= dpx*dy.
	typedef struct packed {
		logic  hit;
		diff_t dx;
		diff_t dpy;
		diff_t dpx;
		diff_t dy;
	} edge_t;

	typedef struct packed {
		edge_t side;
		edge_t close;
		logic  fin;
	} job_t;

endpackage

// ===== src/pip_front.sv =====
// Front end: configuration, vertex tracking and edge classification.
module pip_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pip_pkg::REG_IDX_W-1:0]  wr_index,
	input  pip_pkg::coord_t                wr_data,
	input  logic                           accept,
	input  pip_pkg::coord_t                vertex_x,
	input  pip_pkg::coord_t                vertex_y,
	input  logic                           final_vertex,
	output pip_pkg::job_t                  job
);
	import pip_pkg::*;

	coord_t point_x_q, point_y_q;
	coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic   have_first_q;

	coord_t first_x, first_y;
	logic   close_needed;
	edge_t  side_e, close_e;

	// Order endpoints by y, test the half-open span, form the differences.
	function automatic edge_t classify(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t px, input coord_t py);
		edge_t  e;
		logic   swap;
		coord_t lx, ly, hx, hy;
		swap = by < ay;
		lx = swap ? bx : ax;
		ly = swap ? by : ay;
		hx = swap ? ax : bx;
		hy = swap ? ay : by;
		e.hit = (py >= ly) && (py < hy);
		e.dx  = diff_t'(hx) - diff_t'(lx);
		e.dpy = diff_t'(py) - diff_t'(ly);
		e.dpx = diff_t'(px) - diff_t'(lx);
		e.dy  = diff_t'(hy) - diff_t'(ly);
		return e;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_POINT_X: point_x_q <= wr_data;
				REG_POINT_Y: point_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
		end else if (accept) begin
			if (!have_first_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
			prev_x_q     <= vertex_x;
			prev_y_q     <= vertex_y;
			have_first_q <= !final_vertex;
		end
	end

	always_comb begin
		first_x = have_first_q ? first_x_q : vertex_x;
		first_y = have_first_q ? first_y_q : vertex_y;
		close_needed = final_vertex && ((vertex_x != first_x) || (vertex_y != first_y));
		side_e  = classify(prev_x_q, prev_y_q, vertex_x, vertex_y, point_x_q, point_y_q);
		close_e = classify(vertex_x, vertex_y, first_x, first_y, point_x_q, point_y_q);
		side_e.hit  = side_e.hit && have_first_q;
		close_e.hit = close_e.hit && close_needed;
		job.side  = side_e;
		job.close = close_e;
		job.fin   = final_vertex;
	end

endmodule

// ===== src/pip_edge_q.sv =====
// Short queue of classified edge jobs between front and back end.
module pip_edge_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pip_pkg::job_t  wr_job,
	output logic           full,
	input  logic           rd_en,
	output pip_pkg::job_t  rd_job,
	output logic           rd_valid
);
	import pip_pkg::*;

	job_t                mem_q [EQ_DEPTH];
	logic [EQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [EQ_CNT_W-1:0] cnt_q;

	assign full     = cnt_q == EQ_CNT_W'(EQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + EQ_CNT_W'(wr_en) - EQ_CNT_W'(rd_en);
		end
	end

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + EQ_CNT_W'($past(wr_en)) - EQ_CNT_W'($past(rd_en)))
		else $error("edge queue count out of step with writes and reads");

endmodule

// ===== src/pip_back.sv =====
// Back end: crossing products, parity accumulation and result queue.
module pip_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pip_pkg::job_t  job,
	input  logic           job_valid,
	output logic           job_take,
	output logic           empty,
	input  logic           pop,
	output logic           inside_res
);
	import pip_pkg::*;

	logic                 v_s1, fin_s1, hit0_s1, hit1_s1;
	prod_t                lhs0_s1, rhs0_s1, lhs1_s1, rhs1_s1;
	logic                 parity_q, parity_next, flip0, flip1;
	logic                 out_mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;
	logic                 out_push, out_pop;

	// Issue only when the result queue has room for everything in flight.
	assign job_take = job_valid && ((out_cnt_q + OUT_CNT_W'(v_s1)) < OUT_CNT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= job_take;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			fin_s1  <= job.fin;
			hit0_s1 <= job.side.hit;
			hit1_s1 <= job.close.hit;
			lhs0_s1 <= prod_t'(job.side.dx) * prod_t'(job.side.dpy);
			rhs0_s1 <= prod_t'(job.side.dpx) * prod_t'(job.side.dy);
			lhs1_s1 <= prod_t'(job.close.dx) * prod_t'(job.close.dpy);
			rhs1_s1 <= prod_t'(job.close.dpx) * prod_t'(job.close.dy);
		end
	end

	always_comb begin
		flip0       = hit0_s1 && (lhs0_s1 <= rhs0_s1);
		flip1       = hit1_s1 && (lhs1_s1 <= rhs1_s1);
		parity_next = parity_q ^ flip0 ^ flip1;
		out_push    = v_s1 && fin_s1;
		out_pop     = pop && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (v_s1) begin
			parity_q <= fin_s1 ? 1'b0 : parity_next;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem_q[out_wr_q] <= parity_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
		end
	end

	assign empty      = out_cnt_q == '0;
	assign inside_res = out_mem_q[out_rd_q];

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q + OUT_CNT_W'(v_s1)) <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue credit exceeded");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_cnt_q < OUT_CNT_W'(OUT_DEPTH))
		else $error("result pushed into full queue");

	a_parity_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> parity_q == 1'b0)
		else $error("parity not cleared after closing a polygon");

endmodule

// ===== src/point_in_polygon_even_odd.sv =====
// A final vertex's inside_res passes the edge queue, s1 products and result queue.
// Throughput: one vertex per cycle unless full; a final vertex's edges go in the same cycle.
// The rate is set by the back end: one multiply stage with four 33x33 products per vertex.
// A two-entry edge queue and a four-entry result queue let front and back stall apart.
// Reset (arst_n low, asynchronous): point registers, vertex state and parity clear to zero,
// both queues empty; no clearing pass, the block takes transactions right after reset.
module point_in_polygon_even_odd (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           wr_en,
	input  logic [pip_pkg::REG_IDX_W-1:0]  wr_index,
	input  pip_pkg::coord_t                wr_data,
	// vertex side
	input  logic                           push,
	output logic                           full,
	input  pip_pkg::coord_t                vertex_x,
	input  pip_pkg::coord_t                vertex_y,
	input  logic                           final_vertex,
	// result side
	output logic                           empty,
	input  logic                           pop,
	output logic                           inside_res
);
	import pip_pkg::*;

	logic accept;
	job_t front_job, back_job;
	logic back_valid, back_take;

	// A vertex transaction completes when push is high and the edge queue has room.
	assign accept = push && !full;

	// Front: hold the point, track first and previous vertex, classify the
	// regular edge and, on a final vertex, the closing edge.
	pip_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.accept       (accept),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.final_vertex (final_vertex),
		.job          (front_job)
	);

	// Decouple: the front keeps taking vertices while the back waits on the result side.
	pip_edge_q u_edge_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_job   (front_job),
		.full     (full),
		.rd_en    (back_take),
		.rd_job   (back_job),
		.rd_valid (back_valid)
	);

	// Back: register both cross products per edge, compare, advance the parity,
	// and queue inside_res on the final vertex.
	pip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (back_job),
		.job_valid  (back_valid),
		.job_take   (back_take),
		.empty      (empty),
		.pop        (pop),
		.inside_res (inside_res)
	);

endmodule
